FILE: rtl/frwm_pkg.sv
`timescale 1ns / 1ps
// frwm_pkg: shared types, register indexes and constants of the wildcard flow matcher.
// No dependencies.
package frwm_pkg;

    localparam int WILD_W    = 22;
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;

    // wildcard word bit positions
    localparam int WB_PORT   = 0;
    localparam int WB_VLAN   = 1;
    localparam int WB_MSRC   = 2;
    localparam int WB_MDST   = 3;
    localparam int WB_TYPE   = 4;
    localparam int WB_PROTO  = 5;
    localparam int WB_TSRC   = 6;
    localparam int WB_TDST   = 7;
    localparam int WB_SCNT_LO = 8;
    localparam int WB_DCNT_LO = 14;
    localparam int WB_PCP    = 20;
    localparam int WB_TOS    = 21;

    localparam logic [WILD_W-1:0] WILD_L4   = 22'h0000c0;
    localparam logic [WILD_W-1:0] WILD_L3   = 22'h2fff20;
    localparam logic [WILD_W-1:0] WILD_ALL  = 22'h3fffff;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_WILDCARDS = 3'd0;
    localparam logic [2:0] REG_MAC_SRC   = 3'd1;
    localparam logic [2:0] REG_MAC_DST   = 3'd2;
    localparam logic [2:0] REG_LINK_META = 3'd3;
    localparam logic [2:0] REG_IP_ADDR   = 3'd4;
    localparam logic [2:0] REG_UPPER     = 3'd5;

    localparam logic [15:0] ETH_IP     = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  TOS_MASK   = 8'hfc;

    typedef struct packed {
        logic [WILD_W-1:0] wildcards;
        logic [47:0]       mac_source;
        logic [47:0]       mac_dest;
        logic [50:0]       link_meta;
        logic [63:0]       ip_addresses;
        logic [47:0]       upper_meta;
    } rule_raw_t;

    typedef struct packed {
        logic        port_wild;
        logic        vlan_wild;
        logic        pcp_wild;
        logic        msrc_wild;
        logic        mdst_wild;
        logic        type_wild;
        logic        tos_wild;
        logic        proto_wild;
        logic        tsrc_wild;
        logic        tdst_wild;
        logic [15:0] port;
        logic [15:0] vlan;
        logic [2:0]  pcp;
        logic [47:0] msrc;
        logic [47:0] mdst;
        logic [15:0] eth_type;
        logic [7:0]  tos;
        logic [7:0]  proto;
        logic [31:0] nsrc;
        logic [31:0] ndst;
        logic [31:0] smask;
        logic [31:0] dmask;
        logic [15:0] tsrc;
        logic [15:0] tdst;
    } rule_norm_t;

    localparam rule_norm_t NORM_RESET = '{
        port_wild: 1'b1, vlan_wild: 1'b1, pcp_wild: 1'b1, msrc_wild: 1'b1,
        mdst_wild: 1'b1, type_wild: 1'b1, tos_wild: 1'b1, proto_wild: 1'b1,
        tsrc_wild: 1'b1, tdst_wild: 1'b1,
        port: '0, vlan: '0, pcp: '0, msrc: '0, mdst: '0, eth_type: '0,
        tos: '0, proto: '0, nsrc: '0, ndst: '0, smask: '0, dmask: '0,
        tsrc: '0, tdst: '0
    };

    typedef struct packed {
        logic [15:0] in_port;
        logic [15:0] vlan_id;
        logic [2:0]  vlan_pcp;
        logic [47:0] mac_source;
        logic [47:0] mac_dest;
        logic [15:0] eth_type;
        logic [7:0]  ip_tos;
        logic [7:0]  ip_proto;
        logic [31:0] ip_source;
        logic [31:0] ip_dest;
        logic [15:0] l4_source;
        logic [15:0] l4_dest;
    } key_t;

    // wild count of 32 or more: whole address wild
    function automatic logic [31:0] prefix_mask(input logic [5:0] cnt);
        logic [31:0] m;
        begin
            if (cnt[5])
            begin
                m = '0;
            end
            else
            begin
                m = ~((32'd1 << cnt[4:0]) - 32'd1);
            end
            return m;
        end
    endfunction

endpackage

FILE: rtl/frwm_if.sv
`timescale 1ns / 1ps
// frwm_key_if / frwm_hit_if: valid/ready channels for packet keys and hit words.
// Standalone, no dependencies.
interface frwm_key_if;
    logic        valid;
    logic        ready;
    logic [15:0] in_port;
    logic [15:0] vlan_id;
    logic [2:0]  vlan_pcp;
    logic [47:0] mac_source;
    logic [47:0] mac_dest;
    logic [15:0] eth_type;
    logic [7:0]  ip_tos;
    logic [7:0]  ip_proto;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] l4_source;
    logic [15:0] l4_dest;

    modport source (
        output valid, in_port, vlan_id, vlan_pcp, mac_source, mac_dest, eth_type,
               ip_tos, ip_proto, ip_source, ip_dest, l4_source, l4_dest,
        input  ready
    );
    modport sink (
        input  valid, in_port, vlan_id, vlan_pcp, mac_source, mac_dest, eth_type,
               ip_tos, ip_proto, ip_source, ip_dest, l4_source, l4_dest,
        output ready
    );
endinterface

interface frwm_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

FILE: rtl/frwm_rule_norm.sv
`timescale 1ns / 1ps
// frwm_rule_norm: normalizes the raw rule registers by ethertype and protocol
// and holds the result in a register. Depends on frwm_pkg.
module frwm_rule_norm
    import frwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rule_raw_t  raw,
    output rule_norm_t norm
);

    rule_norm_t        norm_reg;
    rule_norm_t        norm_next;
    logic [WILD_W-1:0] w;
    logic [15:0]       r_type;
    logic [7:0]        raw_proto;

    assign r_type    = raw.link_meta[15:0];
    assign raw_proto = raw.upper_meta[39:32];

    always_comb
    begin
        w         = raw.wildcards;
        norm_next = NORM_RESET;
        norm_next.port     = raw.link_meta[50:35];
        norm_next.vlan     = raw.link_meta[34:19];
        norm_next.pcp      = raw.link_meta[18:16];
        norm_next.eth_type = r_type;
        norm_next.msrc     = raw.mac_source;
        norm_next.mdst     = raw.mac_dest;

        priority if (w[WB_TYPE])
        begin
            w = w | WILD_L3 | WILD_L4;
        end
        else if (r_type == ETH_IP)
        begin
            norm_next.tos   = raw.upper_meta[47:40] & TOS_MASK;
            norm_next.proto = raw_proto;
            norm_next.nsrc  = raw.ip_addresses[63:32];
            norm_next.ndst  = raw.ip_addresses[31:0];
            priority if (w[WB_PROTO])
            begin
                w = w | WILD_L4;
            end
            else if (raw_proto == PROTO_TCP || raw_proto == PROTO_UDP ||
                     raw_proto == PROTO_ICMP)
            begin
                norm_next.tsrc = raw.upper_meta[31:16];
                norm_next.tdst = raw.upper_meta[15:0];
            end
            else
            begin
                w = w & ~WILD_L4;
            end
        end
        else if (r_type == ETH_ARP)
        begin
            norm_next.proto = raw_proto;
            norm_next.nsrc  = raw.ip_addresses[63:32];
            norm_next.ndst  = raw.ip_addresses[31:0];
            w = w & ~WILD_L4;
        end
        else
        begin
            w = w & ~(WILD_L3 | WILD_L4);
        end

        norm_next.port_wild  = w[WB_PORT];
        norm_next.vlan_wild  = w[WB_VLAN];
        norm_next.pcp_wild   = w[WB_PCP];
        norm_next.msrc_wild  = w[WB_MSRC];
        norm_next.mdst_wild  = w[WB_MDST];
        norm_next.type_wild  = w[WB_TYPE];
        norm_next.tos_wild   = w[WB_TOS];
        norm_next.proto_wild = w[WB_PROTO];
        norm_next.tsrc_wild  = w[WB_TSRC];
        norm_next.tdst_wild  = w[WB_TDST];
        norm_next.smask      = prefix_mask(w[WB_SCNT_LO +: 6]);
        norm_next.dmask      = prefix_mask(w[WB_DCNT_LO +: 6]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= NORM_RESET;
        end
        else
        begin
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

    a_type_wild_l3l4: assert property (@(posedge clk) disable iff (!rst_n)
        $past(raw.wildcards[WB_TYPE]) |->
            (norm_reg.tos_wild && norm_reg.proto_wild && norm_reg.tsrc_wild &&
             norm_reg.tdst_wild && norm_reg.smask == '0 && norm_reg.dmask == '0))
        else $error("wildcarded ethertype left L3/L4 fields exact");

    a_other_type_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(raw.wildcards[WB_TYPE]) && $past(r_type) != ETH_IP &&
         $past(r_type) != ETH_ARP) |->
            (!norm_reg.tos_wild && !norm_reg.proto_wild && norm_reg.proto == '0 &&
             norm_reg.smask == '1 && norm_reg.nsrc == '0))
        else $error("non-IP/ARP rule not forced to exact zero L3");

endmodule

FILE: rtl/flow_rule_wildcard_match_top.sv
`timescale 1ns / 1ps
// flow_rule_wildcard_match_top: APB rule registers, normalized rule, key
// register and hit register. Depends on frwm_pkg, frwm_if, frwm_rule_norm.
// The key register and hit register form two stages; a stalled res holds the key.
// Throughput: one key per cycle while the hit output is not stalled.
// A rule write takes effect for keys accepted from the next cycle on.
// Reset: asynchronous active low; rule reads as all-wild, both stages empty.
module flow_rule_wildcard_match_top
    import frwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    frwm_key_if.sink           pkt,
    frwm_hit_if.source         res
);

    rule_raw_t  raw_reg;
    rule_norm_t norm;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    key_t       key_reg;
    logic       key_valid_reg;
    logic       hit_reg;
    logic       hit_next;
    logic       hit_valid_reg;
    logic       out_free;
    logic       advance;
    logic       in_take;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg.wildcards    <= WILD_ALL;
            raw_reg.mac_source   <= '0;
            raw_reg.mac_dest     <= '0;
            raw_reg.link_meta    <= '0;
            raw_reg.ip_addresses <= '0;
            raw_reg.upper_meta   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WILDCARDS: raw_reg.wildcards    <= pwdata[WILD_W-1:0];
                REG_MAC_SRC:   raw_reg.mac_source   <= pwdata[47:0];
                REG_MAC_DST:   raw_reg.mac_dest     <= pwdata[47:0];
                REG_LINK_META: raw_reg.link_meta    <= pwdata[50:0];
                REG_IP_ADDR:   raw_reg.ip_addresses <= pwdata;
                REG_UPPER:     raw_reg.upper_meta   <= pwdata[47:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WILDCARDS: prdata = {{(PDATA_W-WILD_W){1'b0}}, raw_reg.wildcards};
            REG_MAC_SRC:   prdata = {16'd0, raw_reg.mac_source};
            REG_MAC_DST:   prdata = {16'd0, raw_reg.mac_dest};
            REG_LINK_META: prdata = {13'd0, raw_reg.link_meta};
            REG_IP_ADDR:   prdata = raw_reg.ip_addresses;
            REG_UPPER:     prdata = {16'd0, raw_reg.upper_meta};
            default:       prdata = '0;
        endcase
    end

    frwm_rule_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_reg),
        .norm  (norm)
    );

    // handshake
    assign out_free  = !hit_valid_reg || res.ready;
    assign advance   = key_valid_reg && out_free;
    assign pkt.ready = !key_valid_reg || out_free;
    assign in_take   = pkt.valid && pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt.ready)
            begin
                key_valid_reg <= pkt.valid;
            end
            if (out_free)
            begin
                hit_valid_reg <= key_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            key_reg.in_port    <= pkt.in_port;
            key_reg.vlan_id    <= pkt.vlan_id;
            key_reg.vlan_pcp   <= pkt.vlan_pcp;
            key_reg.mac_source <= pkt.mac_source;
            key_reg.mac_dest   <= pkt.mac_dest;
            key_reg.eth_type   <= pkt.eth_type;
            key_reg.ip_tos     <= pkt.ip_tos;
            key_reg.ip_proto   <= pkt.ip_proto;
            key_reg.ip_source  <= pkt.ip_source;
            key_reg.ip_dest    <= pkt.ip_dest;
            key_reg.l4_source  <= pkt.l4_source;
            key_reg.l4_dest    <= pkt.l4_dest;
        end
        if (advance)
        begin
            hit_reg <= hit_next;
        end
    end

    always_comb
    begin
        hit_next = (norm.port_wild  || key_reg.in_port    == norm.port)
                && (norm.vlan_wild  || key_reg.vlan_id    == norm.vlan)
                && (norm.pcp_wild   || key_reg.vlan_pcp   == norm.pcp)
                && (norm.msrc_wild  || key_reg.mac_source == norm.msrc)
                && (norm.mdst_wild  || key_reg.mac_dest   == norm.mdst)
                && (norm.type_wild  || key_reg.eth_type   == norm.eth_type)
                && (norm.tos_wild   || key_reg.ip_tos     == norm.tos)
                && (norm.proto_wild || key_reg.ip_proto   == norm.proto)
                && (((key_reg.ip_source ^ norm.nsrc) & norm.smask) == 32'd0)
                && (((key_reg.ip_dest   ^ norm.ndst) & norm.dmask) == 32'd0)
                && (norm.tsrc_wild  || key_reg.l4_source  == norm.tsrc)
                && (norm.tdst_wild  || key_reg.l4_dest    == norm.tdst);
    end

    assign res.valid = hit_valid_reg;
    assign res.hit   = hit_reg;

    a_take_fills_key: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> key_valid_reg)
        else $error("accepted word not held in key stage");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> hit_valid_reg)
        else $error("key stage word lost on the way to the hit stage");

    a_empty_key_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !key_valid_reg |-> pkt.ready)
        else $error("empty key stage refuses input");

    a_stall_holds_key: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid_reg && !out_free) |=> (key_valid_reg && $stable(key_reg)))
        else $error("stalled key stage changed");

endmodule
